// ----- sv/dbd_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, constants and a helper function for the days-between-dates block.
// Used by dbd_ordinal, days_between_dates and dbd_checker; depends on nothing.

package dbd_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int QUART_W = YEAR_W - 2;        // year / 4
	localparam int CENT_W  = 8;                 // (year / 4) / 25, at most 163
	localparam int ORD_W   = 23;                // day ordinal, below 2**23 for any 14-bit year
	localparam int MDAY_W  = 9;                 // day of year, at most 366
	localparam int DIFF_W  = 22;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	localparam int RECIP_W     = 13;
	localparam int PROD_W      = QUART_W + RECIP_W;
	localparam int RECIP_SHIFT = 17;
	// 5243 / 2**17 rounds 1/25 up closely enough to be exact for 12-bit values
	localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [DIFF_W-1:0] DIFF_MAX = 22'h3FFFFF;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} stage_en_t;

	// days in the whole months before the given month, common year
	function automatic logic [MDAY_W-1:0] months_before(input logic [MONTH_W-1:0] month);
		logic [MDAY_W-1:0] days;
		case (month)
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

// ----- sv/dbd_ordinal.sv -----
`timescale 1ns / 1ps
// Three-stage day-ordinal datapath for one calendar date.
// Depends on dbd_pkg; stage enables come from the top level's pipeline control.

module dbd_ordinal (
	input  logic                          clk,
	input  dbd_pkg::stage_en_t            en,
	input  logic [dbd_pkg::DAY_W-1:0]     day,
	input  logic [dbd_pkg::MONTH_W-1:0]   month,
	input  logic [dbd_pkg::YEAR_W-1:0]    year,
	output logic [dbd_pkg::ORD_W-1:0]     ordinal
);

	logic [dbd_pkg::MONTH_W-1:0] mon_c;
	logic [dbd_pkg::YEAR_W-1:0]  yr_c;
	logic [dbd_pkg::YEAR_W-1:0]  py_c;

	logic [dbd_pkg::YEAR_W-1:0]  py_s1;
	logic [dbd_pkg::MONTH_W-1:0] mon_s1;
	logic [dbd_pkg::DAY_W-1:0]   day_s1;
	logic [1:0]                  yr_lo_s1;
	logic [dbd_pkg::QUART_W-1:0] qy_s1;
	logic [dbd_pkg::PROD_W-1:0]  mp_s1;
	logic [dbd_pkg::PROD_W-1:0]  my_s1;
	logic [dbd_pkg::ORD_W-1:0]   p365_s1;

	logic [dbd_pkg::CENT_W-1:0]  hp;
	logic [dbd_pkg::CENT_W-1:0]  hy;
	logic [dbd_pkg::QUART_W-1:0] hy25;
	logic [dbd_pkg::QUART_W-1:0] r25;
	logic                        leap;
	logic [dbd_pkg::ORD_W-1:0]   years_c;
	logic [dbd_pkg::MDAY_W-1:0]  mdays_c;

	logic [dbd_pkg::ORD_W-1:0]   years_s2;
	logic [dbd_pkg::MDAY_W-1:0]  mdays_s2;
	logic [dbd_pkg::ORD_W-1:0]   ord_s3;

	// clamp month into 1..12 and year zero to one
	always_comb begin
		if (month == '0)
			mon_c = dbd_pkg::MONTH_JAN;
		else if (month > dbd_pkg::MONTH_DEC)
			mon_c = dbd_pkg::MONTH_DEC;
		else
			mon_c = month;
		yr_c = (year == '0) ? dbd_pkg::YEAR_W'(1) : year;
		py_c = yr_c - dbd_pkg::YEAR_W'(1);
	end

	// stage 1: the three multiplies
	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			py_s1    <= py_c;
			mon_s1   <= mon_c;
			day_s1   <= day;
			yr_lo_s1 <= yr_c[1:0];
			qy_s1    <= yr_c[dbd_pkg::YEAR_W-1:2];
			mp_s1    <= dbd_pkg::PROD_W'(py_c[dbd_pkg::YEAR_W-1:2])
				* dbd_pkg::PROD_W'(dbd_pkg::RECIP_25);
			my_s1    <= dbd_pkg::PROD_W'(yr_c[dbd_pkg::YEAR_W-1:2])
				* dbd_pkg::PROD_W'(dbd_pkg::RECIP_25);
			p365_s1  <= dbd_pkg::ORD_W'(py_c) * dbd_pkg::ORD_W'(365);
		end
	end

	// stage 2: leap test and year/month sums
	always_comb begin
		hp   = mp_s1[dbd_pkg::RECIP_SHIFT +: dbd_pkg::CENT_W];
		hy   = my_s1[dbd_pkg::RECIP_SHIFT +: dbd_pkg::CENT_W];
		hy25 = (dbd_pkg::QUART_W'(hy) << 4) + (dbd_pkg::QUART_W'(hy) << 3)
			+ dbd_pkg::QUART_W'(hy);
		r25  = qy_s1 - hy25;
		// year/4 divisible by 25 means a century year; leap only every fourth one
		leap = (yr_lo_s1 == 2'b00) && ((r25 != '0) || (hy[1:0] == 2'b00));
		years_c = p365_s1 + dbd_pkg::ORD_W'(py_s1[dbd_pkg::YEAR_W-1:2])
			- dbd_pkg::ORD_W'(hp) + dbd_pkg::ORD_W'(hp[dbd_pkg::CENT_W-1:2]);
		mdays_c = dbd_pkg::months_before(mon_s1) + dbd_pkg::MDAY_W'(day_s1)
			+ dbd_pkg::MDAY_W'(leap && (mon_s1 > dbd_pkg::MONTH_FEB));
	end

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			years_s2 <= years_c;
			mdays_s2 <= mdays_c;
		end
	end

	// stage 3: final ordinal
	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			ord_s3 <= years_s2 + dbd_pkg::ORD_W'(mdays_s2);
		end
	end

	assign ordinal = ord_s3;

endmodule

// ----- sv/days_between_dates.sv -----
`timescale 1ns / 1ps
// Top level of the days-between-dates block: stream ports, pipeline control, difference stage.
// Depends on dbd_pkg and dbd_ordinal.

// Takes two Gregorian dates per input beat and returns the absolute number of
// days between them, one output beat per input beat, in order. Each date is
// turned into a day ordinal counted from 1 January of year 1 (closed-form leap
// count, month table, day), and the output is the absolute difference of the
// two ordinals, saturated at the field maximum. Month zero reads as January,
// months above twelve as December, year zero as year one; days are used as a
// plain offset from the month start. The block takes one beat per cycle unless
// the output stalls with every stage full. There are three ordinal stages
// (multiplies, leap test and sums, final add) and one subtract stage, which
// is also the output register. Each stage holds its beat only while the
// stage after it is full and stalled, so bubbles close up and input beats
// are taken while a finished result waits on the output, until all are full.

module days_between_dates (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// a_day[4:0], a_month[8:5], a_year[22:9],
	// b_day[27:23], b_month[31:28], b_year[45:32], zero pad[47:46]
	input  logic [dbd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// day_difference[21:0], zero pad[23:22]
	output logic [dbd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	dbd_pkg::stage_en_t en;

	logic [dbd_pkg::ORD_W-1:0]  ord_a;
	logic [dbd_pkg::ORD_W-1:0]  ord_b;
	logic [dbd_pkg::ORD_W-1:0]  diff_c;
	logic [dbd_pkg::DIFF_W-1:0] diff_s4;

	// a stage can take a beat when it is empty or its beat moves on this cycle
	assign rdy_s4 = !v_s4 || m_axis_tready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign s_axis_tready = rdy_s1;
	assign en.en_s1 = rdy_s1;
	assign en.en_s2 = rdy_s2;
	assign en.en_s3 = rdy_s3;

	// advance valid bits alongside the data; hold a stage while it is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_axis_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	dbd_ordinal u_ord_a (
		.clk     (clk),
		.en      (en),
		.day     (s_axis_tdata[4:0]),
		.month   (s_axis_tdata[8:5]),
		.year    (s_axis_tdata[22:9]),
		.ordinal (ord_a)
	);

	dbd_ordinal u_ord_b (
		.clk     (clk),
		.en      (en),
		.day     (s_axis_tdata[27:23]),
		.month   (s_axis_tdata[31:28]),
		.year    (s_axis_tdata[45:32]),
		.ordinal (ord_b)
	);

	// subtract the earlier ordinal from the later one
	assign diff_c = (ord_a > ord_b) ? (ord_a - ord_b) : (ord_b - ord_a);

	// stage 4: saturate into the result field; this is the output register
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			if (diff_c[dbd_pkg::ORD_W-1])
				diff_s4 <= dbd_pkg::DIFF_MAX;
			else
				diff_s4 <= diff_c[dbd_pkg::DIFF_W-1:0];
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {{(dbd_pkg::OUT_TDATA_W - dbd_pkg::DIFF_W){1'b0}}, diff_s4};

endmodule

// ----- sv/dbd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for days_between_dates, attached by the bind at the end of this file.
// Depends on dbd_pkg for the stream widths.

module dbd_port_checks (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [dbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic       in_beat;
	logic       out_beat;
	logic [2:0] inflight_q;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// track beats taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat dropped or changed while stalled");

	// never more beats in flight than pipeline stages
	a_inflight_max: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("more beats in flight than pipeline stages");

	// no result without a beat taken for it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> !m_axis_tvalid)
		else $error("output beat with nothing in flight");

	// an empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output is empty");

	// padding above the result stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[dbd_pkg::OUT_TDATA_W-1:dbd_pkg::DIFF_W] == '0)
		else $error("output padding not zero");

endmodule

bind days_between_dates dbd_port_checks u_dbd_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
